// ===== hw/rtl/fbh_pkg.sv =====
// shared types and codes for the fixed bucket histogram
package fbh_pkg;

    // opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_Q   = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_IDX = 2'd3;

    // register index of the bounds-in-use register
    localparam logic [2:0] REG_BOUNDS_IN_USE = 3'd7;

    // quantile one in Q1.16 and counter ceiling
    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [47:0] CNT_MAX = 48'hFFFF_FFFF_FFFF;

    // request beat
    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] sample_value;
        logic [15:0]        weight;
        logic [16:0]        quantile_q;
        logic [2:0]         bucket_select;
    } req_t;

    // result beat
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] quantile_value;
        logic [47:0]        total_count;
        logic signed [63:0] total_sum;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
        logic               extremes_known;
        logic [47:0]        selected_bucket_count;
    } res_t;

    // commands from the controller
    typedef struct packed {
        logic capture;
        logic add_commit;
        logic clear;
        logic read_emit;
        logic q_check;
        logic walk_step;
        logic div_step;
        logic mul_step;
        logic q_finish;
    } ctl_t;

    // status back to the controller
    typedef struct packed {
        logic q_fail;
        logic walk_emit;
        logic walk_div;
        logic div_full;
        logic div_last;
    } sts_t;

endpackage

// ===== hw/rtl/fbh_ctrl.sv =====
// sequencing state machine for the histogram operations
module fbh_ctrl
    import fbh_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] opcode,
    input  sts_t       sts,
    output logic       busy,
    output ctl_t       ctl
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ADD   = 4'd1;
    localparam logic [3:0] S_CLR   = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_QCHK  = 4'd4;
    localparam logic [3:0] S_QWALK = 4'd5;
    localparam logic [3:0] S_QDIV  = 4'd6;
    localparam logic [3:0] S_QMUL  = 4'd7;
    localparam logic [3:0] S_QFIN  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.capture = 1'b1;
                    unique case (opcode)
                        OP_ADD:   state_next = S_ADD;
                        OP_QUERY: state_next = S_QCHK;
                        OP_CLEAR: state_next = S_CLR;
                        OP_READ:  state_next = S_RD;
                        default:  state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD:
            begin
                ctl.add_commit = 1'b1;
                state_next     = S_IDLE;
            end
            S_CLR:
            begin
                ctl.clear  = 1'b1;
                state_next = S_IDLE;
            end
            S_RD:
            begin
                ctl.read_emit = 1'b1;
                state_next    = S_IDLE;
            end
            S_QCHK:
            begin
                ctl.q_check = 1'b1;
                state_next  = sts.q_fail ? S_IDLE : S_QWALK;
            end
            S_QWALK:
            begin
                ctl.walk_step = 1'b1;
                if (sts.walk_emit)
                begin
                    state_next = S_IDLE;
                end
                else if (sts.walk_div)
                begin
                    state_next = sts.div_full ? S_QMUL : S_QDIV;
                end
            end
            S_QDIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                ctl.mul_step = 1'b1;
                state_next   = S_QFIN;
            end
            S_QFIN:
            begin
                ctl.q_finish = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // an accepted beat always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // the divider is only entered from the walk
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_QDIV) |-> ($past(state_reg) == S_QWALK || $past(state_reg) == S_QDIV))
        else $error("divider entered from wrong state");
`endif

endmodule

// ===== hw/rtl/fbh_dpath.sv =====
// histogram store, bound compares, quantile walk, divider, multiply and result register
module fbh_dpath
    import fbh_pkg::*;
#(
    parameter int NUM_BOUNDS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  req_t        req,
    input  ctl_t        ctl,
    output sts_t        sts,
    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output res_t        res,
    output logic        done
);

    localparam int BUCKETS = NUM_BOUNDS + 1;
    localparam int IDX_W   = $clog2(BUCKETS);
    localparam int KW      = IDX_W + 1;

    // configuration
    logic signed [31:0] bound_reg [NUM_BOUNDS];
    logic [2:0]         biu_reg;
    logic [2:0]         n_eff;

    // histogram state
    logic [47:0]        cnt_reg  [BUCKETS];
    logic [47:0]        cnt_next [BUCKETS];
    logic [47:0]        total_reg, total_next;
    logic signed [63:0] sum_reg, sum_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;
    logic               seen_reg, seen_next;

    // captured beat
    logic signed [31:0] v_reg;
    logic [15:0]        w_reg;
    logic signed [47:0] prod_reg;
    logic [IDX_W-1:0]   kadd_reg;
    logic [16:0]        q_reg;
    logic [2:0]         sel_reg;
    logic [64:0]        target_reg;

    // quantile walk and interpolation
    logic [KW-1:0]      k_reg;
    logic [47:0]        cum_reg;
    logic [63:0]        r_reg;
    logic [63:0]        den_reg;
    logic [31:0]        f_reg;
    logic [4:0]         bit_reg;
    logic               full_reg;
    logic               neg_reg;
    logic [31:0]        mag_reg;
    logic signed [31:0] start_reg;
    logic [31:0]        off_reg;

    // results
    res_t               res_reg, res_next;
    logic               done_reg;
    logic               emit;

    // combinational helpers
    logic [IDX_W-1:0]   kadd;
    logic signed [48:0] prod_full;
    logic [64:0]        tgt;
    logic [48:0]        bsum, tsum;
    logic [64:0]        sumx;
    logic [IDX_W-1:0]   kidx, km1;
    logic               walk_past, walk_stop, k_zero;
    logic [47:0]        cnt_k;
    logic [48:0]        cnext;
    logic signed [31:0] lo_b, hi_b;
    logic [32:0]        diff, ndiff;
    logic [64:0]        num_w;
    logic [63:0]        den_w;
    logic               full_w;
    logic [64:0]        r2;
    logic               ge;
    logic [63:0]        mprod;
    logic [32:0]        qres;

    // bounds in use, clamped to the legal range
    always_comb
    begin
        if (biu_reg == 3'd0)
        begin
            n_eff = 3'd1;
        end
        else if (biu_reg > 3'(NUM_BOUNDS))
        begin
            n_eff = 3'(NUM_BOUNDS);
        end
        else
        begin
            n_eff = biu_reg;
        end
    end

    // bucket search: first used bound above the sample, else the top bucket
    always_comb
    begin
        kadd = n_eff[IDX_W-1:0];
        for (int j = NUM_BOUNDS - 1; j >= 0; j--)
        begin
            if ((3'(j) < n_eff) && (req.sample_value < bound_reg[j]))
            begin
                kadd = IDX_W'(j);
            end
        end
    end

    // product and quantile target formed at capture
    assign prod_full = req.sample_value * $signed({1'b0, req.weight});
    assign tgt       = 65'(req.quantile_q) * 65'(total_reg);

    // walk step
    assign kidx      = k_reg[IDX_W-1:0];
    assign km1       = kidx - 1'b1;
    assign walk_past = 4'(k_reg) > 4'(n_eff);
    assign k_zero    = (k_reg == '0);
    assign cnt_k     = walk_past ? 48'd0 : cnt_reg[kidx];
    assign cnext     = {1'b0, cum_reg} + {1'b0, cnt_k};
    assign walk_stop = (cnext > {1'b0, total_reg}) || ({cnext, 16'h0} >= target_reg);
    assign lo_b      = bound_reg[km1];
    assign hi_b      = (4'(k_reg) < 4'(n_eff)) ? bound_reg[kidx] : max_reg;
    assign diff      = {hi_b[31], hi_b} - {lo_b[31], lo_b};
    assign ndiff     = -diff;
    assign num_w     = target_reg - {1'b0, cum_reg, 16'h0};
    assign den_w     = {cnt_k, 16'h0};
    assign full_w    = num_w >= {1'b0, den_w};

    // one quotient bit a cycle
    assign r2 = {r_reg, 1'b0};
    assign ge = r2 >= {1'b0, den_reg};

    // offset multiply and final sum
    assign mprod = 64'(mag_reg) * 64'(f_reg);
    assign qres  = neg_reg ? ({start_reg[31], start_reg} - {1'b0, off_reg})
                           : ({start_reg[31], start_reg} + {1'b0, off_reg});

    // status to the controller
    always_comb
    begin
        sts.q_fail    = (q_reg > ONE_Q16) || (total_reg == 48'd0);
        sts.walk_emit = walk_past || (walk_stop && (k_zero || (cnt_k == 48'd0)));
        sts.walk_div  = !walk_past && walk_stop && !k_zero && (cnt_k != 48'd0);
        sts.div_full  = full_w;
        sts.div_last  = (bit_reg == 5'd31);
    end

    // histogram next state
    always_comb
    begin
        for (int b = 0; b < BUCKETS; b++)
        begin
            cnt_next[b] = cnt_reg[b];
        end
        total_next = total_reg;
        sum_next   = sum_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        seen_next  = seen_reg;
        bsum       = {1'b0, cnt_reg[kadd_reg]} + 49'(w_reg);
        tsum       = {1'b0, total_reg} + 49'(w_reg);
        sumx       = {sum_reg[63], sum_reg} + {{17{prod_reg[47]}}, prod_reg};
        if (ctl.add_commit)
        begin
            cnt_next[kadd_reg] = bsum[48] ? CNT_MAX : bsum[47:0];
            total_next         = tsum[48] ? CNT_MAX : tsum[47:0];
            if (sumx[64] != sumx[63])
            begin
                sum_next = sumx[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            end
            else
            begin
                sum_next = sumx[63:0];
            end
            if (!seen_reg || (v_reg < min_reg))
            begin
                min_next = v_reg;
            end
            if (!seen_reg || (v_reg > max_reg))
            begin
                max_next = v_reg;
            end
            seen_next = 1'b1;
        end
        else if (ctl.clear)
        begin
            for (int b = 0; b < BUCKETS; b++)
            begin
                cnt_next[b] = 48'd0;
            end
            total_next = 48'd0;
            sum_next   = 64'sd0;
            min_next   = 32'sd0;
            max_next   = 32'sd0;
            seen_next  = 1'b0;
        end
    end

    // result beat
    always_comb
    begin
        emit                           = 1'b0;
        res_next.status                = ST_OK;
        res_next.quantile_value        = 32'sd0;
        res_next.total_count           = total_next;
        res_next.total_sum             = sum_next;
        res_next.min_value             = min_next;
        res_next.max_value             = max_next;
        res_next.extremes_known        = seen_next;
        res_next.selected_bucket_count = 48'd0;
        if (ctl.add_commit || ctl.clear)
        begin
            emit = 1'b1;
        end
        else if (ctl.read_emit)
        begin
            emit = 1'b1;
            if (sel_reg > n_eff)
            begin
                res_next.status = ST_BAD_IDX;
            end
            else
            begin
                res_next.selected_bucket_count = cnt_reg[sel_reg[IDX_W-1:0]];
            end
        end
        else if (ctl.q_check && sts.q_fail)
        begin
            emit            = 1'b1;
            res_next.status = (q_reg > ONE_Q16) ? ST_BAD_Q : ST_EMPTY;
        end
        else if (ctl.walk_step && sts.walk_emit)
        begin
            emit = 1'b1;
            if (walk_past)
            begin
                res_next.quantile_value = max_reg;
            end
            else if (k_zero)
            begin
                res_next.quantile_value = min_reg;
            end
            else
            begin
                res_next.quantile_value = lo_b;
            end
        end
        else if (ctl.q_finish)
        begin
            emit                    = 1'b1;
            res_next.quantile_value = qres[31:0];
        end
    end

    // configuration and histogram registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_BOUNDS; j++)
            begin
                bound_reg[j] <= 32'sd0;
            end
            biu_reg <= 3'd7;
            for (int b = 0; b < BUCKETS; b++)
            begin
                cnt_reg[b] <= 48'd0;
            end
            total_reg <= 48'd0;
            sum_reg   <= 64'sd0;
            min_reg   <= 32'sd0;
            max_reg   <= 32'sd0;
            seen_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_BOUNDS_IN_USE)
                begin
                    biu_reg <= cfg_data[2:0];
                end
                else
                begin
                    for (int j = 0; j < NUM_BOUNDS; j++)
                    begin
                        if (cfg_index == 3'(j))
                        begin
                            bound_reg[j] <= cfg_data;
                        end
                    end
                end
            end
            for (int b = 0; b < BUCKETS; b++)
            begin
                cnt_reg[b] <= cnt_next[b];
            end
            total_reg <= total_next;
            sum_reg   <= sum_next;
            min_reg   <= min_next;
            max_reg   <= max_next;
            seen_reg  <= seen_next;
            done_reg  <= emit;
        end
    end

    // beat capture, walk, divider and multiply working registers and the result register
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            v_reg      <= req.sample_value;
            w_reg      <= req.weight;
            prod_reg   <= prod_full[47:0];
            kadd_reg   <= kadd;
            q_reg      <= req.quantile_q;
            sel_reg    <= req.bucket_select;
            target_reg <= tgt;
        end
        if (ctl.q_check)
        begin
            k_reg   <= '0;
            cum_reg <= 48'd0;
        end
        if (ctl.walk_step)
        begin
            if (!walk_stop)
            begin
                k_reg   <= k_reg + 1'b1;
                cum_reg <= cnext[47:0];
            end
            r_reg     <= num_w[63:0];
            den_reg   <= den_w;
            full_reg  <= full_w;
            neg_reg   <= diff[32];
            mag_reg   <= diff[32] ? ndiff[31:0] : diff[31:0];
            start_reg <= lo_b;
            bit_reg   <= 5'd0;
            f_reg     <= 32'd0;
        end
        if (ctl.div_step)
        begin
            r_reg   <= ge ? 64'(r2 - {1'b0, den_reg}) : r2[63:0];
            f_reg   <= {f_reg[30:0], ge};
            bit_reg <= bit_reg + 1'b1;
        end
        if (ctl.mul_step)
        begin
            off_reg <= full_reg ? mag_reg : mprod[63:32];
        end
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

`ifndef SYNTHESIS
    // extremes read zero until a sample is seen
    a_extremes_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !seen_reg |-> (min_reg == 32'sd0 && max_reg == 32'sd0))
        else $error("extremes set without a sample");

    // the walk never passes the total count
    a_walk_cum: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.walk_step |-> (cum_reg <= total_reg))
        else $error("cumulative count above total");
`endif

endmodule

// ===== hw/rtl/fixed_bucket_histogram_core.sv =====
// top level of the fixed bucket histogram with quantile estimate
// A beat is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and must be taken then. Add,
// clear and read capture the beat and then do their work in a state of their
// own; a new beat is taken only once the block is idle again. A quantile
// query runs a check, a walk over the cumulative counts of the buckets in
// use, then a one-bit-per-cycle serial divider for the 32-bit in-bucket
// fraction, a multiply and a final add. Queries that end at the minimum,
// the maximum, a bound or on an error skip the divider, as does one whose
// fraction is a full one. Configuration writes are always ready and should
// be made while the block is idle.
module fixed_bucket_histogram_core
    import fbh_pkg::*;
#(
    parameter int NUM_BOUNDS = 7
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        request,
    output logic        done,
    output res_t        result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    ctl_t ctl;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // controller
    fbh_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .sts    (sts),
        .busy   (busy),
        .ctl    (ctl)
    );

    // datapath
    fbh_dpath #(
        .NUM_BOUNDS (NUM_BOUNDS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (request),
        .ctl       (ctl),
        .sts       (sts),
        .cfg_write (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (result),
        .done      (done)
    );

`ifndef SYNTHESIS
    // results are spaced, never back to back
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done on consecutive cycles");
`endif

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for the fixed bucket histogram core
module tb_top;
    import fbh_pkg::*;

    localparam int NB = 7;
    localparam int N_RANDOM = 1950;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    req_t        request = '0;
    logic        done;
    res_t        result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    fixed_bucket_histogram_core #(.NUM_BOUNDS(NB)) dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // predictor state
    logic signed [31:0] bnd [NB];
    logic [2:0]         bnd_used;
    logic [47:0]        bkt [8];
    logic [47:0]        cnt_total;
    logic signed [63:0] wsum;
    logic signed [31:0] smallest, largest;
    logic               seen;

    req_t   pending_req [$];
    res_t   expected_res [$];
    int     fail_count = 0;
    bit     quiet = 1'b0;

    function automatic int used_n();
        if (bnd_used == 0) return 1;
        if (bnd_used > NB) return NB;
        return int'(bnd_used);
    endfunction

    function automatic logic [47:0] sat48(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? CNT_MAX : s[47:0];
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < 8; i++) bkt[i] = '0;
        cnt_total = '0;
        wsum = '0;
        smallest = '0;
        largest = '0;
        seen = 1'b0;
    endfunction

    // one-bit-per-step fraction num/den in Q1.32
    function automatic logic [32:0] fraction_q32(logic [63:0] num, logic [63:0] den);
        logic [63:0] r;
        logic [32:0] f;
        r = num;
        f = '0;
        if (num >= den) return 33'h1_0000_0000;
        for (int i = 0; i < 32; i++) begin
            f = f << 1;
            if (r >= den - r) begin
                r = r - (den - r);
                f[0] = 1'b1;
            end
            else r = r + r;
        end
        return f;
    endfunction

    function automatic logic [1:0] quantile_estimate(logic [16:0] q, output logic signed [31:0] v);
        int n, k;
        logic [63:0] target, cum, c, b, num, den, mag, off;
        logic [32:0] f;
        logic [95:0] prod;
        logic signed [63:0] s0, e0, diff;
        n = used_n();
        k = 0;
        cum = '0;
        v = '0;
        if (q > ONE_Q16) return ST_BAD_Q;
        if (cnt_total == 0) return ST_EMPTY;
        target = 64'(q) * 64'(cnt_total);
        while (k <= n) begin
            c = cum + 64'(bkt[k]);
            if (c > 64'(cnt_total) || (c << 16) >= target) break;
            cum = c;
            k++;
        end
        if (k == 0) begin
            v = smallest;
            return ST_OK;
        end
        if (k > n) begin
            v = largest;
            return ST_OK;
        end
        b = 64'(bkt[k]);
        s0 = 64'(bnd[k-1]);
        e0 = (k < n) ? 64'(bnd[k]) : 64'(largest);
        if (b == 0) begin
            v = s0[31:0];
            return ST_OK;
        end
        num = target - (cum << 16);
        den = b << 16;
        f = fraction_q32(num, den);
        diff = e0 - s0;
        mag = diff < 0 ? -diff : diff;
        prod = 96'(mag) * 96'(f);
        off = prod[95:32];
        v = diff < 0 ? 32'(s0 - off) : 32'(s0 + off);
        return ST_OK;
    endfunction

    function automatic res_t histogram_step(req_t r);
        res_t o;
        int k, n;
        logic signed [63:0] p;
        o = '0;
        n = used_n();
        case (r.opcode)
            OP_ADD: begin
                k = 0;
                p = 64'(r.sample_value) * $signed({1'b0, r.weight});
                while (k < n && r.sample_value >= bnd[k]) k++;
                bkt[k] = sat48(bkt[k], 48'(r.weight));
                cnt_total = sat48(cnt_total, 48'(r.weight));
                if (p > 0 && wsum > 64'sh7FFF_FFFF_FFFF_FFFF - p)
                    wsum = 64'sh7FFF_FFFF_FFFF_FFFF;
                else if (p < 0 && wsum < $signed(64'h8000_0000_0000_0000) - p)
                    wsum = $signed(64'h8000_0000_0000_0000);
                else wsum = wsum + p;
                if (!seen || r.sample_value < smallest) smallest = r.sample_value;
                if (!seen || r.sample_value > largest) largest = r.sample_value;
                seen = 1'b1;
            end
            OP_QUERY: begin
                o.status = quantile_estimate(r.quantile_q, o.quantile_value);
                if (o.status != ST_OK) o.quantile_value = '0;
            end
            OP_CLEAR: clear_histogram();
            default: begin
                if (r.bucket_select > n) o.status = ST_BAD_IDX;
                else o.selected_bucket_count = bkt[r.bucket_select];
            end
        endcase
        o.total_count = cnt_total;
        o.total_sum = wsum;
        o.min_value = smallest;
        o.max_value = largest;
        o.extremes_known = seen;
        return o;
    endfunction

    // driver: issues pending beats, idles at random outside quiet stretches
    always @(posedge clk) begin
        req_t cur;
        if (rst_n) begin
            if (start && !busy) begin
                cur = pending_req.pop_front();
                expected_res = {expected_res, histogram_step(cur)};
                if (pending_req.size() > 0 && (quiet || $urandom_range(99) >= 17))
                    request <= pending_req[0];
                else
                    start <= 1'b0;
            end
            else if (!start && pending_req.size() > 0
                     && (quiet || $urandom_range(99) >= 17)) begin
                start <= 1'b1;
                request <= pending_req[0];
            end
        end
    end

    // monitor: compare each result beat with the oldest expectation
    always @(posedge clk) begin
        res_t e;
        if (rst_n && done) begin
            if (expected_res.size() == 0) begin
                $error("result beat with nothing expected");
                fail_count++;
            end
            else begin
                e = expected_res.pop_front();
                if (result.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, result.status); fail_count++;
                end
                if (result.quantile_value !== e.quantile_value) begin
                    $error("quantile_value exp %0d got %0d", e.quantile_value,
                           result.quantile_value); fail_count++;
                end
                if (result.total_count !== e.total_count) begin
                    $error("total_count exp %0d got %0d", e.total_count,
                           result.total_count); fail_count++;
                end
                if (result.total_sum !== e.total_sum) begin
                    $error("total_sum exp %0d got %0d", e.total_sum, result.total_sum);
                    fail_count++;
                end
                if (result.min_value !== e.min_value) begin
                    $error("min_value exp %0d got %0d", e.min_value, result.min_value);
                    fail_count++;
                end
                if (result.max_value !== e.max_value) begin
                    $error("max_value exp %0d got %0d", e.max_value, result.max_value);
                    fail_count++;
                end
                if (result.extremes_known !== e.extremes_known) begin
                    $error("extremes_known exp %0d got %0d", e.extremes_known,
                           result.extremes_known); fail_count++;
                end
                if (result.selected_bucket_count !== e.selected_bucket_count) begin
                    $error("selected_bucket_count exp %0d got %0d",
                           e.selected_bucket_count, result.selected_bucket_count);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_BOUNDS_IN_USE) bnd_used = val[2:0];
        else bnd[idx] = val;
    endtask

    task automatic wait_idle();
        while (pending_req.size() > 0 || expected_res.size() > 0 || start)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic req_t make_req(logic [1:0] op, logic signed [31:0] v,
                                      logic [15:0] w, logic [16:0] q, logic [2:0] sel);
        req_t r;
        r.opcode = op;
        r.sample_value = v;
        r.weight = w;
        r.quantile_q = q;
        r.bucket_select = sel;
        return r;
    endfunction

    // append a beat to the driver's queue
    function automatic void queue_req(req_t r);
        pending_req = {pending_req, r};
    endfunction

    // random beat, mostly adds with samples spread around the bounds
    function automatic req_t random_req(int span);
        req_t r;
        int pick;
        r = '0;
        r.sample_value = $urandom;
        r.weight = 16'($urandom);
        r.quantile_q = 17'($urandom);
        r.bucket_select = 3'($urandom);
        pick = $urandom_range(99);
        if (pick < 60) begin
            r.opcode = OP_ADD;
            if ($urandom_range(3) != 0)
                r.sample_value = 32'($signed($urandom_range(2 * span)) - span);
            if ($urandom_range(3) != 0) r.weight = 16'($urandom_range(300));
        end
        else if (pick < 82) begin
            r.opcode = OP_QUERY;
            if ($urandom_range(4) != 0) r.quantile_q = 17'($urandom_range(65536));
        end
        else if (pick < 85) r.opcode = OP_CLEAR;
        else r.opcode = OP_READ;
        return r;
    endfunction

    task automatic bounds_setting(input int lo, input int step, input int used);
        for (int i = 0; i < NB; i++) write_reg(3'(i), 32'(lo + i * step));
        write_reg(REG_BOUNDS_IN_USE, 32'(used));
    endtask

    initial begin
        for (int i = 0; i < NB; i++) bnd[i] = '0;
        bnd_used = 3'd7;
        clear_histogram();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, all opcodes, error cases
        bounds_setting(-300, 100, 7);
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd0, 3'd0));
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd65537, 3'd0));
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'h1FFFF, 3'd0));
        queue_req(make_req(OP_ADD, 32'sh7FFF_FFFF, 16'hFFFF, 17'd0, 3'd0));
        queue_req(make_req(OP_ADD, 32'sh8000_0000, 16'hFFFF, 17'd0, 3'd0));
        queue_req(make_req(OP_ADD, 32'sd5, 16'd0, 17'd0, 3'd0));
        queue_req(make_req(OP_ADD, -32'sd250, 16'd10, 17'd0, 3'd0));
        queue_req(make_req(OP_ADD, 32'sd150, 16'd7, 17'd0, 3'd0));
        for (int s = 0; s < 8; s++)
            queue_req(make_req(OP_READ, 32'sd0, 16'd0, 17'd0, 3'(s)));
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd0, 3'd0));
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd32768, 3'd0));
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd65536, 3'd0));
        queue_req(make_req(OP_CLEAR, 32'sd0, 16'd0, 17'd0, 3'd0));
        for (int i = 0; i < 6; i++)
            queue_req(make_req(OP_ADD, 32'sh7FFF_FFFF, 16'hFFFF, 17'd0, 3'd0));
        wait_idle();

        // few bounds, unsorted bounds, zero bounds in use and a wide sample span, in random phases
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: bounds_setting(-1000, 300, 7);
                1: bounds_setting(-2147483647, 0, 1);
                2: begin
                    bounds_setting(500, -200, 3);
                    write_reg(3'd6, 32'h8000_0000);
                end
                3: begin
                    bounds_setting(-40, 20, 4);
                    write_reg(REG_BOUNDS_IN_USE, 32'd0);
                end
                4: bounds_setting(-2147483647, 613566756, 7);
                default: bounds_setting(0, 1, 2);
            endcase
            quiet = (ph == 2);
            for (int i = 0; i < N_RANDOM / 6; i++)
                queue_req(random_req(ph == 4 ? 2147483647 : 1500));
            wait_idle();
        end
        // quantile extremes once more after a large fill
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd1, 3'd0));
        queue_req(make_req(OP_QUERY, 32'sd0, 16'd0, 17'd65535, 3'd0));
        wait_idle();

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #40000000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
